@@ sv/ssp_pkg.sv @@
// Shared types, constants and the speed-to-period table for the stepper pulser.
package ssp_pkg;

  localparam int unsigned AngleW   = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned PeriodW  = 8;
  localparam int unsigned MagW     = 15;
  localparam int unsigned ProdW    = 31;

  localparam logic [15:0] FullTurn  = 16'd36000;
  localparam logic [15:0] HalfTurn  = 16'd18000;
  localparam logic [16:0] Turns1    = 17'd36000;
  localparam logic [16:0] Turns2    = 17'd72000;
  localparam logic [16:0] Turns3    = 17'd108000;

  // floor(x / 36000) = floor(floor(x / 32) / 1125); the second step uses an
  // exact reciprocal for 26-bit dividends: ceil(2^37 / 1125).
  localparam int unsigned PreShift  = 5;
  localparam int unsigned ScaledW   = ProdW - PreShift;
  localparam int unsigned RecipW    = 27;
  localparam int unsigned RecipSh   = 37;
  localparam int unsigned RecipProdW = ScaledW + RecipW;
  localparam logic [RecipW-1:0] RecipM = 27'd122167959;

  localparam logic [15:0] PprReset = 16'd200;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_LOOP    = 3'd2,
    OP_DISABLE = 3'd3,
    OP_INIT    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_PPR    = 2'd0,
    CFG_SPEED  = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_idx_e;

  // Move computed in the first stage and handed to the state update.
  typedef struct packed {
    logic [AngleW-1:0] fresh;
    logic              dir;
    logic              load;
    logic [ProdW-1:0]  prod;
  } move_t;

  // Period in ticks: 150 - floor(level*80/9).
  function automatic logic [PeriodW-1:0] period_f(logic [3:0] lvl);
    logic [PeriodW-1:0] p;
    case (lvl)
      4'd1:    p = 8'd142;
      4'd2:    p = 8'd133;
      4'd3:    p = 8'd124;
      4'd4:    p = 8'd115;
      4'd5:    p = 8'd106;
      4'd6:    p = 8'd97;
      4'd7:    p = 8'd88;
      4'd8:    p = 8'd79;
      4'd9:    p = 8'd70;
      4'd10:   p = 8'd62;
      4'd11:   p = 8'd53;
      4'd12:   p = 8'd44;
      4'd13:   p = 8'd35;
      4'd14:   p = 8'd26;
      4'd15:   p = 8'd17;
      default: p = 8'd150;
    endcase
    return p;
  endfunction

endpackage

@@ sv/ssp_if.sv @@
// Valid/ready channel interfaces for pulser commands and status beats.
interface ssp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] target_angle;

  modport source(output valid, operation, target_angle, input ready);
  modport sink(input valid, operation, target_angle, output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic        step_line;
  logic        direction;
  logic        driver_enable;
  logic        running;
  logic [15:0] remaining_toggles;

  modport source(output valid, step_line, direction, driver_enable, running,
                 remaining_toggles, input ready);
  modport sink(input valid, step_line, direction, driver_enable, running,
               remaining_toggles, output ready);
endinterface

@@ sv/stepper_shortest_path_pulser_top.sv @@
// Top level of the shortest-path stepper pulse generator.
// Every command beat yields exactly one status beat that reports the state after the
// command: step line level, direction, driver enable, pulse timer running and toggles
// still to emit. Tick, loop, disable and unknown beats are taken one per clock while the
// output slot is free, and their status appears in the cycle after the command leaves
// the input register. Set-angle and init beats first wrap the target, fold the move onto
// the short way round and register pulses_per_rev times the angle difference; the divide
// stage then divides that product by one full turn through a reciprocal multiplier and
// loads the toggle count. The input register holds its command while a beat waits in the
// divide stage. An output register decouples the two channels; while a status beat waits,
// the input register still takes one new command, and a set-angle or init beat still
// moves on into the divide stage. Registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; index 0 pulses_per_rev, 1 speed_level, 2 angle_offset, other indexes are
// dropped. Write them only while the block is idle.
module stepper_shortest_path_pulser_top import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  ssp_in_if.sink      in_i,
  ssp_out_if.source   out_o
);

  // Configuration registers.
  logic [15:0]       ppr_q;
  logic [3:0]        speed_q;
  logic [AngleW-1:0] offset_q;

  // Input register.
  logic              in_vld_q;
  logic [2:0]        op_q;
  logic [AngleW-1:0] tgt_q;

  // Block state.
  logic [AngleW-1:0]  last_q, last_d;
  logic [CountW-1:0]  tog_q, tog_d;
  logic               step_q, step_d;
  logic               dir_q, dir_d;
  logic               timer_q, timer_d;
  logic               en_q, en_d;
  logic               done_q, done_d;
  logic [PeriodW-1:0] pc_q, pc_d;

  // Divide stage.
  logic               pend_q, pend_d;
  logic               load_q, load_d;
  logic [ProdW-1:0]   prod_q, prod_d;

  // Output register.
  logic               out_vld_q, out_vld_d;
  logic               o_step_q, o_dir_q, o_en_q, o_run_q;
  logic [CountW-1:0]  o_tog_q;

  op_e                op;
  logic               div_op;
  logic               out_free;
  logic               fire_a;
  logic               fire_b;
  logic               fire_res;
  logic               in_ready;
  move_t              mv;
  logic [CountW-1:0]  quot;

  // Period elapse terms.
  logic [PeriodW-1:0] period;
  logic               elapse;
  logic [CountW-1:0]  el_tog;
  logic               el_done;
  logic               el_fin;

  assign op       = op_e'(op_q);
  assign div_op   = (op == OP_SET) || (op == OP_INIT);
  assign out_free = ~out_vld_q | out_o.ready;
  // A set-angle or init beat parks in the divide stage; others need the output slot.
  assign fire_a   = in_vld_q & ~pend_q & (div_op | out_free);
  assign fire_b   = pend_q & out_free;
  assign fire_res = (fire_a & ~div_op) | fire_b;
  assign in_ready = ~in_vld_q | fire_a;
  assign in_i.ready = in_ready;

  ssp_angle u_angle (
    .target_i (tgt_q),
    .offset_i (offset_q),
    .last_i   (last_q),
    .ppr_i    (ppr_q),
    .move_o   (mv)
  );

  ssp_div u_div (
    .prod_i (prod_q),
    .quot_o (quot)
  );

  assign period  = period_f(speed_q);
  // A stale counter at or past period-1 counts as elapsed.
  assign elapse  = ({1'b0, pc_q} + 9'd1) >= {1'b0, period};
  assign el_tog  = (tog_q != '0) ? (tog_q - 16'd1) : tog_q;
  assign el_done = (tog_q != '0) ? 1'b0 : done_q;
  assign el_fin  = (el_tog == '0) & ~el_done;

  always_comb begin
    last_d  = last_q;
    tog_d   = tog_q;
    step_d  = step_q;
    dir_d   = dir_q;
    timer_d = timer_q;
    en_d    = en_q;
    done_d  = done_q;
    pc_d    = pc_q;
    pend_d  = pend_q;
    load_d  = load_q;
    prod_d  = prod_q;

    if (fire_a) begin
      case (op)
        OP_TICK: begin
          if (timer_q) begin
            if (elapse) begin
              pc_d   = '0;
              tog_d  = el_tog;
              step_d = (tog_q != '0) ? ~step_q : step_q;
              done_d = el_done | el_fin;
              if (el_fin) begin
                timer_d = 1'b0;
              end
            end else begin
              pc_d = pc_q + 8'd1;
            end
          end
        end
        OP_SET: begin
          pc_d    = '0;
          timer_d = 1'b1;
        end
        OP_LOOP: begin
          if (tog_q == '0) begin
            pc_d    = '0;
            timer_d = 1'b1;
            tog_d   = ppr_q;
          end
        end
        OP_DISABLE: begin
          timer_d = 1'b0;
        end
        OP_INIT: begin
          timer_d = 1'b0;
          en_d    = 1'b1;
        end
        default: begin
        end
      endcase
      // Shared move prep for set-angle and init; toggles load from the divide stage.
      if (div_op) begin
        last_d = mv.fresh;
        if (mv.load) begin
          dir_d = mv.dir;
        end
        pend_d = 1'b1;
        load_d = mv.load;
        prod_d = mv.prod;
      end
    end

    if (fire_b) begin
      pend_d = 1'b0;
      if (load_q) begin
        tog_d = quot;
      end
    end
  end

  assign out_vld_d = fire_res | (out_vld_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q     <= PprReset;
      speed_q   <= '0;
      offset_q  <= '0;
      in_vld_q  <= 1'b0;
      last_q    <= '0;
      tog_q     <= '0;
      step_q    <= 1'b0;
      dir_q     <= 1'b0;
      timer_q   <= 1'b0;
      en_q      <= 1'b0;
      done_q    <= 1'b0;
      pc_q      <= '0;
      pend_q    <= 1'b0;
      load_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PPR:    ppr_q    <= cfg_data_i;
          CFG_SPEED:  speed_q  <= cfg_data_i[3:0];
          CFG_OFFSET: offset_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        in_vld_q <= in_i.valid;
      end
      last_q    <= last_d;
      tog_q     <= tog_d;
      step_q    <= step_d;
      dir_q     <= dir_d;
      timer_q   <= timer_d;
      en_q      <= en_d;
      done_q    <= done_d;
      pc_q      <= pc_d;
      pend_q    <= pend_d;
      load_q    <= load_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      op_q  <= in_i.operation;
      tgt_q <= in_i.target_angle;
    end
    prod_q <= prod_d;
    if (fire_res) begin
      o_step_q <= step_d;
      o_dir_q  <= dir_d;
      o_en_q   <= en_d;
      o_run_q  <= timer_d;
      o_tog_q  <= tog_d;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.step_line         = o_step_q;
  assign out_o.direction         = o_dir_q;
  assign out_o.driver_enable     = o_en_q;
  assign out_o.running           = o_run_q;
  assign out_o.remaining_toggles = o_tog_q;

`ifndef SYNTHESIS
  // The divide stage drains as soon as the output slot frees.
  a_pend_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && out_free |=> !pend_q)
    else $error("divide stage did not drain");

  // A tick never moves the stored angle.
  a_tick_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_a && op == OP_TICK |=> $stable(last_q))
    else $error("tick changed last angle");

  // A tick only counts toggles down.
  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_a && op == OP_TICK && !pend_q |=> tog_q <= $past(tog_q))
    else $error("tick raised toggle count");

  // The timer stops once a run has spent its count.
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_a && op == OP_TICK && timer_q && elapse && el_fin |=> !timer_q)
    else $error("timer kept running after last toggle");
`endif

endmodule

@@ sv/ssp_angle.sv @@
// Target wrap, shortest-way fold and toggle product for a set-angle or init beat.
module ssp_angle import ssp_pkg::*; (
  input  logic [AngleW-1:0] target_i,
  input  logic [AngleW-1:0] offset_i,
  input  logic [AngleW-1:0] last_i,
  input  logic [15:0]       ppr_i,
  output move_t             move_o
);

  logic [16:0]       sum;
  logic [16:0]       wrapped;
  logic [AngleW-1:0] fresh;
  logic              up;
  logic [AngleW-1:0] mag_raw;
  logic              fold;
  logic [AngleW-1:0] mag_full;
  logic [MagW-1:0]   mag;

  assign sum = {1'b0, target_i} + {1'b0, offset_i};

  // Sum stays below four turns: a compare chain picks which multiple of a turn to subtract.
  always_comb begin
    if (sum >= Turns3) begin
      wrapped = sum - Turns3;
    end else if (sum >= Turns2) begin
      wrapped = sum - Turns2;
    end else if (sum >= Turns1) begin
      wrapped = sum - Turns1;
    end else begin
      wrapped = sum;
    end
  end

  assign fresh    = wrapped[AngleW-1:0];
  assign up       = fresh > last_i;
  assign mag_raw  = up ? (fresh - last_i) : (last_i - fresh);
  assign fold     = mag_raw > HalfTurn;
  assign mag_full = fold ? (FullTurn - mag_raw) : mag_raw;
  assign mag      = mag_full[MagW-1:0];

  assign move_o.fresh = fresh;
  assign move_o.dir   = fold ? up : ~up;
  assign move_o.load  = fresh != last_i;
  assign move_o.prod  = ProdW'(ppr_i) * ProdW'(mag);

endmodule

@@ sv/ssp_div.sv @@
// Exact divide of the registered toggle product by one full turn.
module ssp_div import ssp_pkg::*; (
  input  logic [ProdW-1:0]  prod_i,
  output logic [CountW-1:0] quot_o
);

  logic [ScaledW-1:0]    scaled;
  logic [RecipProdW-1:0] wide;

  assign scaled = prod_i[ProdW-1:PreShift];
  assign wide   = RecipProdW'(scaled) * RecipProdW'(RecipM);
  assign quot_o = wide[RecipSh +: CountW];

endmodule
